>>> rtl/mhp_pkg.sv
// mhp_pkg: shared types, codes and layout helpers of the mac header parser
// no dependencies; imported by the output interface and every module of the block
`default_nettype none

package mhp_pkg;

  // frames longer than this many bytes are rejected
  localparam int unsigned MaxFrameBytes = 127;

  // frame control bit positions
  localparam int unsigned FcfSecBit  = 3;
  localparam int unsigned FcfCompBit = 6;

  // address mode codes
  localparam logic [1:0] AM_NONE  = 2'd0;
  localparam logic [1:0] AM_RSVD  = 2'd1;
  localparam logic [1:0] AM_SHORT = 2'd2;
  localparam logic [1:0] AM_EXT   = 2'd3;

  // key identifier mode codes
  localparam logic [1:0] KM_IMPLICIT = 2'd0;
  localparam logic [1:0] KM_INDEX    = 2'd1;
  localparam logic [1:0] KM_SRC4     = 2'd2;
  localparam logic [1:0] KM_SRC8     = 2'd3;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SECURED     = 2'd1,
    ST_MALFORMED   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  // byte index inside the addressing part of the header (at most 23)
  typedef logic [4:0] pos_t;

  localparam pos_t DpanAt = 5'd3;

  typedef struct packed {
    logic       has_dpan;
    logic       has_span;
    pos_t       dadr_at;
    logic [3:0] dlen;
    pos_t       span_at;
    pos_t       sadr_at;
    logic [3:0] slen;
    pos_t       hdr_end;
  } layout_t;

  // frame state after the current word has been taken in
  typedef struct packed {
    logic [7:0]  pos;
    logic [15:0] fcf;
    logic [7:0]  seq;
    logic [15:0] dpan;
    logic [63:0] daddr;
    logic [15:0] span;
    logic [63:0] saddr;
    logic [7:0]  sec_ctl;
    pos_t        hdr_end;
    status_t     verdict;
  } cap_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] frame_control;
    logic [7:0]  sequence_number;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [15:0] src_pan;
    logic [63:0] src_address;
    logic [6:0]  payload_start;
    logic [6:0]  payload_length;
  } res_t;

  function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
    logic [3:0] len;
    unique case (mode)
      AM_SHORT: len = 4'd2;
      AM_EXT:   len = 4'd8;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] key_id_len(input logic [1:0] kmode);
    logic [3:0] len;
    unique case (kmode)
      KM_INDEX: len = 4'd1;
      KM_SRC4:  len = 4'd5;
      KM_SRC8:  len = 4'd9;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic layout_t make_layout(input logic [15:0] fcf);
    logic [1:0] dmode;
    logic [1:0] smode;
    logic       comp;
    pos_t       pos;
    layout_t    l;
    dmode      = fcf[11:10];
    smode      = fcf[15:14];
    comp       = fcf[FcfCompBit];
    l.has_dpan = (dmode != AM_NONE);
    pos        = DpanAt + (l.has_dpan ? 5'd2 : 5'd0);
    l.dadr_at  = pos;
    l.dlen     = l.has_dpan ? addr_bytes(dmode) : 4'd0;
    pos        = pos + {1'b0, l.dlen};
    l.has_span = (smode != AM_NONE) && !(comp && l.has_dpan);
    l.span_at  = pos;
    pos        = pos + (l.has_span ? 5'd2 : 5'd0);
    l.sadr_at  = pos;
    l.slen     = addr_bytes(smode);
    pos        = pos + {1'b0, l.slen};
    l.hdr_end  = pos;
    return l;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mhp_in_if.sv
// mhp_in_if: frame byte channel, valid/ready with byte and last mark
// no dependencies
`default_nettype none

interface mhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/mhp_out_if.sv
// mhp_out_if: parsed header channel, valid/ready with one result per frame
// depends on mhp_pkg for the status type
`default_nettype none

interface mhp_out_if import mhp_pkg::*;;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] frame_control;
  logic [7:0]  sequence_number;
  logic [15:0] dest_pan;
  logic [63:0] dest_address;
  logic [15:0] src_pan;
  logic [63:0] src_address;
  logic [6:0]  payload_start;
  logic [6:0]  payload_length;

  modport source (output valid, status, frame_control, sequence_number, dest_pan,
                  dest_address, src_pan, src_address, payload_start, payload_length,
                  input ready);
  modport sink (input valid, status, frame_control, sequence_number, dest_pan,
                dest_address, src_pan, src_address, payload_start, payload_length,
                output ready);
endinterface

`default_nettype wire

>>> rtl/mhp_byte_capture.sv
// mhp_byte_capture: per-frame state, places each byte into its header field
// depends on mhp_pkg for layout helpers and the cap_t view
`default_nettype none

module mhp_byte_capture import mhp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output cap_t       cap
);

  logic [7:0]  byte_count;
  logic [15:0] fcf;
  logic [7:0]  seq;
  logic [15:0] dpan;
  logic [63:0] daddr;
  logic [15:0] span;
  logic [63:0] saddr;
  logic [7:0]  sec_ctl;
  pos_t        hdr_end;
  status_t     verdict;

  logic [7:0]  byte_count_next;
  logic [15:0] fcf_next;
  logic [7:0]  seq_next;
  logic [15:0] dpan_next;
  logic [63:0] daddr_next;
  logic [15:0] span_next;
  logic [63:0] saddr_next;
  logic [7:0]  sec_ctl_next;
  pos_t        hdr_end_next;
  status_t     verdict_next;

  layout_t     lay;
  layout_t     lay_new;
  logic [7:0]  p;
  logic [1:0]  dmode_new;
  logic [1:0]  smode_new;

  assign p               = byte_count;
  assign byte_count_next = (&byte_count) ? byte_count : byte_count + 8'd1;
  assign lay             = make_layout(fcf);
  assign lay_new         = make_layout(fcf_next);
  assign dmode_new       = fcf_next[11:10];
  assign smode_new       = fcf_next[15:14];

  always_comb begin
    fcf_next     = fcf;
    seq_next     = seq;
    dpan_next    = dpan;
    daddr_next   = daddr;
    span_next    = span;
    saddr_next   = saddr;
    sec_ctl_next = sec_ctl;
    hdr_end_next = hdr_end;
    verdict_next = verdict;
    if (p == 8'd0) begin
      fcf_next = {8'h00, data_byte};
    end else if (p == 8'd1) begin
      fcf_next = {data_byte, fcf[7:0]};
    end else begin
      if (p == 8'd2) begin
        seq_next = data_byte;
      end
      if (lay.has_dpan && p == {3'b000, DpanAt}) begin
        dpan_next[7:0] = data_byte;
      end
      if (lay.has_dpan && p == {3'b000, DpanAt} + 8'd1) begin
        dpan_next[15:8] = data_byte;
      end
      if (lay.has_span && p == {3'b000, lay.span_at}) begin
        span_next[7:0] = data_byte;
      end
      if (lay.has_span && p == {3'b000, lay.span_at} + 8'd1) begin
        span_next[15:8] = data_byte;
      end
      for (int k = 0; k < 8; k++) begin
        if (4'(k) < lay.dlen && p == {3'b000, lay.dadr_at} + 8'(k)) begin
          daddr_next[8*k +: 8] = data_byte;
        end
        if (4'(k) < lay.slen && p == {3'b000, lay.sadr_at} + 8'(k)) begin
          saddr_next[8*k +: 8] = data_byte;
        end
      end
      if (fcf[FcfSecBit] && p == {3'b000, lay.hdr_end}) begin
        sec_ctl_next = data_byte;
      end
    end
    // early verdict once the whole frame control word is known
    if (p == 8'd1) begin
      hdr_end_next = lay_new.hdr_end;
      if (dmode_new == AM_RSVD || smode_new == AM_RSVD) begin
        verdict_next = ST_MALFORMED;
      end else if (fcf_next[13] || fcf_next[9:8] != 2'b00) begin
        verdict_next = ST_UNSUPPORTED;
      end else begin
        verdict_next = ST_OK;
      end
    end
  end

  always_comb begin
    cap.pos     = p;
    cap.fcf     = fcf_next;
    cap.seq     = seq_next;
    cap.dpan    = dpan_next;
    cap.daddr   = daddr_next;
    cap.span    = span_next;
    cap.saddr   = saddr_next;
    cap.sec_ctl = sec_ctl_next;
    cap.hdr_end = hdr_end_next;
    cap.verdict = verdict_next;
  end

  // state clears after the last word so every frame starts from zero
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_count <= '0;
      fcf        <= '0;
      seq        <= '0;
      dpan       <= '0;
      daddr      <= '0;
      span       <= '0;
      saddr      <= '0;
      sec_ctl    <= '0;
      hdr_end    <= '0;
      verdict    <= ST_OK;
    end else if (step) begin
      byte_count <= byte_count_next;
      fcf        <= fcf_next;
      seq        <= seq_next;
      dpan       <= dpan_next;
      daddr      <= daddr_next;
      span       <= span_next;
      saddr      <= saddr_next;
      sec_ctl    <= sec_ctl_next;
      hdr_end    <= hdr_end_next;
      verdict    <= verdict_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mhp_frame_check.sv
// mhp_frame_check: end-of-frame checks, security header length and payload span
// depends on mhp_pkg for cap_t, res_t and layout helpers
`default_nettype none

module mhp_frame_check import mhp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytes
) (
  input  cap_t cap,
  output res_t res
);

  logic [8:0] n;
  logic [8:0] hdr_total;
  logic [8:0] total;
  logic [8:0] body;
  logic       secured;
  logic       too_long;
  layout_t    lay;
  status_t    st;

  assign n         = {1'b0, cap.pos} + 9'd1;
  assign secured   = cap.fcf[FcfSecBit];
  assign hdr_total = {4'b0000, cap.hdr_end};
  assign too_long  = (cap.pos >= 8'(MAX_FRAME_BYTES));
  assign lay       = make_layout(cap.fcf);

  // auxiliary security header: control byte, frame counter, key identifier
  always_comb begin
    total = hdr_total;
    if (secured) begin
      total = hdr_total + 9'd1 + (cap.sec_ctl[5] ? 9'd0 : 9'd4)
              + {5'b00000, key_id_len(cap.sec_ctl[4:3])};
    end
  end

  assign body = n - total;

  always_comb begin
    if (too_long || cap.pos == 8'd0) begin
      st = ST_MALFORMED;
    end else if (cap.verdict != ST_OK) begin
      st = cap.verdict;
    end else if (n < hdr_total) begin
      st = ST_MALFORMED;
    end else if (secured && (n <= hdr_total || n < total)) begin
      st = ST_MALFORMED;
    end else if (total > 9'd127 || body > 9'd127) begin
      st = ST_MALFORMED;
    end else begin
      st = secured ? ST_SECURED : ST_OK;
    end
  end

  always_comb begin
    res               = '0;
    res.status        = st;
    res.frame_control = cap.fcf;
    if (st == ST_OK || st == ST_SECURED) begin
      res.sequence_number = cap.seq;
      res.dest_pan        = cap.dpan;
      res.dest_address    = cap.daddr;
      res.src_address     = cap.saddr;
      res.payload_start   = total[6:0];
      res.payload_length  = body[6:0];
      if (cap.fcf[15:14] != AM_NONE && cap.fcf[FcfCompBit] && lay.has_dpan) begin
        res.src_pan = cap.dpan;
      end else begin
        res.src_pan = cap.span;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mac_header_parser_unit.sv
// mac_header_parser_unit: top level of the mac frame header parser
// depends on mhp_pkg, mhp_in_if, mhp_out_if, mhp_byte_capture, mhp_frame_check
//
//   channel     dir  word                          handshake
//   frame_in    in   data_byte, last_byte          valid/ready, one frame byte
//   header_out  out  status .. payload_length      valid/ready, one per frame
//
// a byte is taken every cycle while no last byte waits for a held result; it
// is registered in the input register, then the capture logic and end-of-frame
// checks run in that stage and the last byte of a frame loads the result
// register. a held result stalls only a stage holding a last byte; other bytes
// keep flowing. reset (rst, synchronous) empties both registers and clears
// the frame state.
`default_nettype none

module mac_header_parser_unit import mhp_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytes
) (
  input  logic             clk,
  input  logic             rst,
  mhp_in_if.sink           frame_in,
  mhp_out_if.source        header_out
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // result register
  logic       res_valid;
  res_t       res;

  logic       res_free;
  logic       s1_fire;
  cap_t       cap;
  res_t       res_next;

  // a last byte needs the result register to be free, other bytes never wait
  assign res_free       = !res_valid || header_out.ready;
  assign s1_fire        = s1_valid && (!s1_last || res_free);
  assign frame_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_in.ready) begin
      s1_valid <= frame_in.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (frame_in.ready && frame_in.valid) begin
      s1_byte <= frame_in.data_byte;
      s1_last <= frame_in.last_byte;
    end
  end

  mhp_byte_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_fire),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .cap       (cap)
  );

  mhp_frame_check #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_check (
    .cap (cap),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      res_valid <= 1'b1;
    end else if (header_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      res <= res_next;
    end
  end

  // result word to the output channel
  assign header_out.valid           = res_valid;
  assign header_out.status          = res.status;
  assign header_out.frame_control   = res.frame_control;
  assign header_out.sequence_number = res.sequence_number;
  assign header_out.dest_pan        = res.dest_pan;
  assign header_out.dest_address    = res.dest_address;
  assign header_out.src_pan         = res.src_pan;
  assign header_out.src_address     = res.src_address;
  assign header_out.payload_start   = res.payload_start;
  assign header_out.payload_length  = res.payload_length;

endmodule

`default_nettype wire
